// ===== hw/rtl/aplh_pkg.sv =====
// Shared types and constants for the audio peak-level histogram.
// No dependencies; imported by every module of the block.
package aplh_pkg;

  localparam int unsigned SampleW     = 16;
  localparam int unsigned CountW      = 16;
  localparam int unsigned BinW        = 4;
  localparam int unsigned CfgW        = 16;
  localparam int unsigned BinsDefault = 16;

  localparam logic [SampleW-1:0] PeakReset      = 16'h8000;
  localparam logic [CfgW-1:0]    ThresholdReset = 16'd5000;
  localparam logic [CfgW-1:0]    BinWidthReset  = 16'd500;

  typedef enum logic {
    FuncSample = 1'b0,
    FuncRead   = 1'b1
  } func_e;

  typedef enum logic {
    RegThreshold = 1'b0,
    RegBinWidth  = 1'b1
  } reg_index_e;

endpackage

// ===== hw/rtl/aplh_bin_match.sv =====
// Bin limit registers and first-match priority encoder for the histogram.
// Depends on aplh_pkg.
module aplh_bin_match import aplh_pkg::*; #(
  parameter int unsigned Bins = BinsDefault,
  localparam int unsigned IdxW = (Bins > 1) ? $clog2(Bins) : 1
) (
  input  logic                      clk_i,
  input  logic [CfgW-1:0]           threshold_i,
  input  logic [CfgW-1:0]           bin_width_i,
  input  logic signed [SampleW-1:0] peak_i,
  output logic [IdxW-1:0]           idx_o
);

  logic [CfgW-1:0] limit_q [Bins];
  logic [Bins-1:0] hit;

  // Limits are registered; config must be written only while idle, unchecked here.
  for (genvar x = 0; x < Bins; x++) begin : g_lane
    logic [CfgW-1:0] step;
    logic [CfgW-1:0] limit_d;

    assign step    = CfgW'(32'(x + 1) * 32'(bin_width_i));
    assign limit_d = CfgW'(threshold_i + step);

    always_ff @(posedge clk_i) begin
      limit_q[x] <= limit_d;
    end

    assign hit[x] = $signed({peak_i[SampleW-1], peak_i}) <= $signed({1'b0, limit_q[x]});
  end

  // Lowest matching bin wins; fall back to the last bin.
  always_comb begin
    idx_o = IdxW'(Bins - 1);
    for (int x = Bins - 1; x >= 0; x--) begin
      if (hit[x]) begin
        idx_o = IdxW'(x);
      end
    end
  end

endmodule

// ===== hw/rtl/audio_peak_level_histogram_top.sv =====
// Top level of the audio peak-level histogram: input stage, peak tracker,
// bin counters and output register. Depends on aplh_pkg and aplh_bin_match.
//
//  channel  direction  handshake                  payload
//  in       sink       in_valid_i / in_stall_o    func, sample, last, bin_select
//  out      source     out_valid_o / out_stall_i  bump, peak, bin, bin_count
//  cfg      sink       cfg_we_i                   cfg_index_i, cfg_data_i
//
// One request per cycle sustained while results are not stalled; a request
// that yields a result shows it on the outputs through the input register,
// then the result register.
// The loop is the running peak and counter update in the processing stage,
// which retires one request each cycle unless the result side stalls.
// Reset sets threshold 5000, bin width 500, sets the peak to the most
// negative sample and clears all counters.
// A stalled result holds the processing stage; the input register then
// stalls the sender. Every request in the processing stage, with or without
// a result, waits there while the result register is full and stalled.
module audio_peak_level_histogram_top import aplh_pkg::*; #(
  parameter int unsigned Bins = BinsDefault,
  localparam int unsigned IdxW = (Bins > 1) ? $clog2(Bins) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // request channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      in_func_i,
  input  logic signed [SampleW-1:0] in_sample_i,
  input  logic                      in_last_i,
  input  logic [BinW-1:0]           in_bin_select_i,
  // result channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      out_bump_o,
  output logic signed [SampleW-1:0] out_peak_o,
  output logic [BinW-1:0]           out_bin_o,
  output logic [CountW-1:0]         out_bin_count_o,
  // configuration
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [CfgW-1:0]           cfg_data_i
);

  // Configuration registers.
  logic [CfgW-1:0] threshold_q;
  logic [CfgW-1:0] bin_width_q;
  logic            clear_counts;

  always_comb begin
    clear_counts = 1'b0;
    if (cfg_we_i && (reg_index_e'(cfg_index_i) == RegThreshold)) begin
      clear_counts = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdReset;
      bin_width_q <= BinWidthReset;
    end else if (cfg_we_i) begin
      case (reg_index_e'(cfg_index_i))
        RegThreshold: threshold_q <= cfg_data_i;
        RegBinWidth:  bin_width_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register.
  logic                      s1_valid_q;
  logic                      s1_func_q;
  logic signed [SampleW-1:0] s1_sample_q;
  logic                      s1_last_q;
  logic [BinW-1:0]           s1_sel_q;
  logic                      out_ready;
  logic                      s1_retire;
  logic                      in_take;

  assign out_ready  = !out_valid_o || !out_stall_i;
  assign s1_retire  = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (out_ready || !s1_valid_q) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_func_q   <= in_func_i;
      s1_sample_q <= in_sample_i;
      s1_last_q   <= in_last_i;
      s1_sel_q    <= in_bin_select_i;
    end
  end

  // Peak tracking.
  logic signed [SampleW-1:0] run_peak_q;
  logic signed [SampleW-1:0] peak_new;
  logic                      is_read;
  logic                      bump;
  logic [IdxW-1:0]           hit_idx;

  assign is_read  = (func_e'(s1_func_q) == FuncRead);
  assign peak_new = (s1_sample_q > run_peak_q) ? s1_sample_q : run_peak_q;
  assign bump     = !is_read && s1_last_q &&
                    ($signed({peak_new[SampleW-1], peak_new}) > $signed({1'b0, threshold_q}));

  aplh_bin_match #(
    .Bins (Bins)
  ) u_bin_match (
    .clk_i       (clk_i),
    .threshold_i (threshold_q),
    .bin_width_i (bin_width_q),
    .peak_i      (peak_new),
    .idx_o       (hit_idx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_peak_q <= PeakReset;
    end else if (s1_retire && !is_read) begin
      // Restart the peak at every batch end.
      run_peak_q <= s1_last_q ? PeakReset : peak_new;
    end
  end

  // Bin counters.
  logic [CountW-1:0] counts_q [Bins];
  logic [CountW-1:0] hit_next;
  logic              rd_in_range;
  logic [CountW-1:0] rd_count;

  assign hit_next    = CountW'(counts_q[hit_idx] + 1'b1);
  assign rd_in_range = (32'(s1_sel_q) < Bins);
  assign rd_count    = rd_in_range ? counts_q[IdxW'(s1_sel_q)] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int x = 0; x < Bins; x++) begin
        counts_q[x] <= '0;
      end
    end else if (clear_counts) begin
      for (int x = 0; x < Bins; x++) begin
        counts_q[x] <= '0;
      end
    end else if (s1_retire && bump) begin
      counts_q[hit_idx] <= hit_next;
    end
  end

  // Result register.
  logic                      res_valid;
  logic                      out_valid_q;
  logic                      out_bump_q;
  logic signed [SampleW-1:0] out_peak_q;
  logic [BinW-1:0]           out_bin_q;
  logic [CountW-1:0]         out_bin_count_q;
  logic signed [SampleW-1:0] res_peak;
  logic [BinW-1:0]           res_bin;
  logic [CountW-1:0]         res_count;

  assign res_valid = s1_valid_q && (is_read || s1_last_q);

  always_comb begin
    if (is_read) begin
      res_peak  = '0;
      res_bin   = s1_sel_q;
      res_count = rd_count;
    end else if (bump) begin
      res_peak  = peak_new;
      res_bin   = BinW'(hit_idx);
      res_count = hit_next;
    end else begin
      res_peak  = peak_new;
      res_bin   = '0;
      res_count = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && res_valid) begin
      out_bump_q      <= bump;
      out_peak_q      <= res_peak;
      out_bin_q       <= res_bin;
      out_bin_count_q <= res_count;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_bump_o      = out_bump_q;
  assign out_peak_o      = out_peak_q;
  assign out_bin_o       = out_bin_q;
  assign out_bin_count_o = out_bin_count_q;

endmodule

// ===== verif/aplh_tb_pkg.sv =====
// Scoreboard for the audio peak-level histogram testbench: result type,
// predictor of the peak tracker and bin counters, and the queue of results.
// Depends on aplh_pkg for widths, reset values and codes.
package aplh_tb_pkg;
  import aplh_pkg::*;

  typedef struct {
    logic                      bump;
    logic signed [SampleW-1:0] peak;
    logic [BinW-1:0]           bin;
    logic [CountW-1:0]         count;
  } level_result_t;

  class peak_histogram_scoreboard;
    logic [CfgW-1:0]           threshold;
    logic [CfgW-1:0]           bin_width;
    logic signed [SampleW-1:0] running_peak;
    logic [CountW-1:0]         level_counts [BinsDefault];
    level_result_t             pending_results [$];
    int unsigned               mismatches;
    int unsigned               requests;
    int unsigned               results;
    int unsigned               bumps;

    function new();
      mismatches = 0;
      requests   = 0;
      results    = 0;
      bumps      = 0;
      threshold    = ThresholdReset;
      bin_width    = BinWidthReset;
      running_peak = PeakReset;
      foreach (level_counts[i]) level_counts[i] = '0;
    endfunction

    function void write_reg(reg_index_e idx, logic [CfgW-1:0] data);
      if (idx == RegThreshold) begin
        threshold = data;
        foreach (level_counts[i]) level_counts[i] = '0;
      end else begin
        bin_width = data;
      end
    endfunction

    // Append one predicted result at the tail of the queue.
    function void queue_result(level_result_t r);
      pending_results.insert(pending_results.size(), r);
    endfunction

    // Predict the result of one accepted request, if it has one.
    function void note_request(func_e func, logic signed [SampleW-1:0] sample,
                               logic is_last, logic [BinW-1:0] sel);
      level_result_t r;
      int peak;
      int thr;
      int bw;
      int limit;
      int idx;
      requests++;
      if (func == FuncRead) begin
        r.bump  = 1'b0;
        r.peak  = '0;
        r.bin   = sel;
        r.count = (sel < BinsDefault) ? level_counts[sel] : '0;
        queue_result(r);
        return;
      end
      peak = running_peak;
      if (int'(sample) > peak) peak = sample;
      if (!is_last) begin
        running_peak = peak[SampleW-1:0];
        return;
      end
      running_peak = PeakReset;
      thr = threshold;
      bw  = bin_width;
      r.peak = peak[SampleW-1:0];
      if (peak > thr) begin
        idx = BinsDefault - 1;
        for (int x = 0; x < BinsDefault; x++) begin
          limit = (thr + (x + 1) * bw) & 32'hFFFF;
          if (peak <= limit) begin
            idx = x;
            break;
          end
        end
        level_counts[idx] = level_counts[idx] + 1'b1;
        r.bump  = 1'b1;
        r.bin   = idx[BinW-1:0];
        r.count = level_counts[idx];
      end else begin
        r.bump  = 1'b0;
        r.bin   = '0;
        r.count = '0;
      end
      queue_result(r);
    endfunction

    function void check_result(level_result_t got);
      level_result_t want;
      results++;
      if (got.bump) bumps++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: bump=%0d peak=%0d bin=%0d count=%0d",
                   got.bump, got.peak, got.bin, got.count);
        return;
      end
      want = pending_results.pop_front();
      if (got.bump !== want.bump || got.peak !== want.peak ||
          got.bin !== want.bin || got.count !== want.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected bump=%0d peak=%0d bin=%0d count=%0d, ",
                    "got bump=%0d peak=%0d bin=%0d count=%0d"},
                   want.bump, want.peak, want.bin, want.count,
                   got.bump, got.peak, got.bin, got.count);
      end
    endfunction
  endclass

endpackage

// ===== verif/audio_peak_level_histogram_top_tb.sv =====
// Testbench for audio_peak_level_histogram_top: directed and random requests
// under random idling on both channels, checked against aplh_tb_pkg's scoreboard.
// Depends on aplh_pkg and aplh_tb_pkg.
module audio_peak_level_histogram_top_tb;
  import aplh_pkg::*;
  import aplh_tb_pkg::*;

  localparam int unsigned PhaseCount = 9;
  localparam int unsigned PhaseItems = 145;

  logic                      clk           = 1'b0;
  logic                      rst_n         = 1'b0;
  logic                      in_valid      = 1'b0;
  logic                      in_stall;
  func_e                     in_func       = FuncSample;
  logic signed [SampleW-1:0] in_sample     = '0;
  logic                      in_last       = 1'b0;
  logic [BinW-1:0]           in_bin_select = '0;
  logic                      out_valid;
  logic                      out_stall     = 1'b0;
  logic                      out_bump;
  logic signed [SampleW-1:0] out_peak;
  logic [BinW-1:0]           out_bin;
  logic [CountW-1:0]         out_bin_count;
  logic                      cfg_we        = 1'b0;
  reg_index_e                cfg_index     = RegThreshold;
  logic [CfgW-1:0]           cfg_data      = '0;

  // Idling switch shared by sender and receiver; cleared for a quiet stretch.
  bit                        idle_en       = 1'b1;
  int unsigned               requests_sent = 0;
  int unsigned               read_count    = 0;
  int unsigned               setting_count = 0;
  level_result_t             seen_result;
  peak_histogram_scoreboard  hist_sb;

  // Register settings for the random phases: wraparound limits, zero width,
  // a threshold nothing can pass, and a width-only write that keeps the counts.
  logic [CfgW-1:0] phase_thr   [PhaseCount] =
    '{16'd0, 16'd65535, 16'd30000, 16'd0, 16'd1000, 16'd32766, 16'd0, 16'd0, 16'd5000};
  logic [CfgW-1:0] phase_bw    [PhaseCount] =
    '{16'd1, 16'd65535, 16'd40000, 16'd2048, 16'd0, 16'd1, 16'd0, 16'd0, 16'd500};
  bit              phase_wr_thr[PhaseCount] = '{1, 1, 1, 1, 1, 1, 1, 0, 1};

  always #5 clk = ~clk;

  audio_peak_level_histogram_top uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .in_func_i       (in_func),
    .in_sample_i     (in_sample),
    .in_last_i       (in_last),
    .in_bin_select_i (in_bin_select),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .out_bump_o      (out_bump),
    .out_peak_o      (out_peak),
    .out_bin_o       (out_bin),
    .out_bin_count_o (out_bin_count),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // Stall the result channel about a third of the time while idling is on.
  always @(posedge clk) begin
    out_stall <= idle_en && ($urandom_range(0, 99) < 33);
  end

  // Note every accepted request and check every accepted result. Both sides
  // read values from before the edge, so one block keeps their order fixed.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        hist_sb.note_request(in_func, in_sample, in_last, in_bin_select);
      if (out_valid && !out_stall) begin
        seen_result.bump  = out_bump;
        seen_result.peak  = out_peak;
        seen_result.bin   = out_bin;
        seen_result.count = out_bin_count;
        hist_sb.check_result(seen_result);
      end
    end
  end

  // Present one request, idling first at random, and hold it until accepted.
  task automatic send_request(func_e f, logic signed [SampleW-1:0] s, logic l,
                              logic [BinW-1:0] sel);
    while (idle_en && ($urandom_range(0, 99) < 33)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= f;
    in_sample     <= s;
    in_last       <= l;
    in_bin_select <= sel;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    if (f == FuncRead) read_count++;
  endtask

  // Read a random bin; sample and last carry junk the block must ignore.
  task automatic send_read();
    send_request(FuncRead, SampleW'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                 BinW'($urandom_range(0, 15)));
  endtask

  // Drop valid, wait for every predicted result, then let the pipe empty of
  // requests that produce nothing.
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (hist_sb.pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller lowers it.
  task automatic write_reg(reg_index_e idx, logic [CfgW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    hist_sb.write_reg(idx, data);
  endtask

  task automatic apply_setting(bit do_thr, logic [CfgW-1:0] thr, logic [CfgW-1:0] bw);
    drain();
    if (do_thr) write_reg(RegThreshold, thr);
    write_reg(RegBinWidth, bw);
    cfg_we <= 1'b0;
    @(posedge clk);
    setting_count++;
  endtask

  // Mix extremes, values around the threshold and bin limits, and full-range
  // noise. Limits above the sample range clip to the largest sample.
  function automatic logic signed [SampleW-1:0] pick_sample();
    int lim;
    case ($urandom_range(0, 9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2, 3, 4: begin
        lim = (int'(hist_sb.threshold) + $urandom_range(0, 16) * int'(hist_sb.bin_width))
              & 32'hFFFF;
        lim = lim + int'($urandom_range(0, 2)) - 1;
        if (lim > 32767) lim = 32767;
        if (lim < -32768) lim = -32768;
        return lim[SampleW-1:0];
      end
      default: return SampleW'($urandom_range(0, 65535));
    endcase
  endfunction

  // One batch, mostly short, with reads slipped in between its samples.
  task automatic send_batch();
    int len;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0) send_read();
      send_request(FuncSample, pick_sample(), (k == len - 1), BinW'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    int unsigned phase_end;
    int unsigned fails;
    hist_sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset values, bin edges, no-bump batches, reads with junk.
    send_request(FuncRead, -16'sd1, 1'b1, 4'd0);
    send_request(FuncRead, 16'sd0, 1'b0, 4'd15);
    send_request(FuncSample, 16'sd32767, 1'b1, 4'd0);
    send_request(FuncSample, -16'sd32768, 1'b0, 4'd0);
    send_request(FuncSample, 16'sd5200, 1'b0, 4'd15);
    send_request(FuncSample, 16'sd100, 1'b1, 4'd0);
    send_request(FuncSample, 16'sd5000, 1'b1, 4'd0);
    send_request(FuncSample, 16'sd5001, 1'b1, 4'd0);
    send_request(FuncSample, 16'sd5500, 1'b1, 4'd0);
    send_request(FuncSample, 16'sd5501, 1'b1, 4'd0);
    send_request(FuncSample, -16'sd32768, 1'b1, 4'd0);
    send_request(FuncSample, 16'sd0, 1'b0, 4'd0);
    send_request(FuncSample, -16'sd1, 1'b1, 4'd0);
    send_request(FuncRead, 16'sd32767, 1'b0, 4'd0);
    send_request(FuncRead, 16'sd0, 1'b1, 4'd1);
    // Zero bin width sends every bump to the last bin; the counts survive.
    apply_setting(1'b0, 16'd0, 16'd0);
    send_request(FuncSample, 16'sd5001, 1'b1, 4'd0);
    send_request(FuncRead, 16'sd0, 1'b0, 4'd0);
    // Threshold write clears; first limit wraps below the peak.
    apply_setting(1'b1, 16'd30000, 16'd40000);
    send_request(FuncSample, 16'sd31000, 1'b1, 4'd0);
    send_request(FuncRead, 16'sd0, 1'b0, 4'd0);
    send_request(FuncRead, 16'sd0, 1'b0, 4'd1);
    apply_setting(1'b1, 16'd65535, 16'd65535);
    send_request(FuncSample, 16'sd32767, 1'b1, 4'd0);
    apply_setting(1'b1, 16'd0, 16'd65535);
    send_request(FuncSample, 16'sd1, 1'b1, 4'd0);
    send_request(FuncSample, 16'sd0, 1'b1, 4'd0);

    // Random phases, one register setting each.
    for (int p = 0; p < PhaseCount; p++) begin
      if (p == 6) begin
        phase_thr[p] = CfgW'($urandom_range(0, 32767));
        phase_bw[p]  = CfgW'($urandom_range(1, 4095));
      end
      if (p == 7) phase_bw[p] = CfgW'($urandom_range(1, 65535));
      apply_setting(phase_wr_thr[p], phase_thr[p], phase_bw[p]);
      // Quiet stretch: no idling on either side for a whole phase.
      idle_en = (p != 3);
      phase_end = requests_sent + PhaseItems;
      while (requests_sent < phase_end) begin
        if ($urandom_range(0, 99) < 15) send_read();
        else send_batch();
        // Hold the sender near mid-phase until every predicted result is out.
        if (p == 4 && requests_sent >= phase_end - PhaseItems / 2 &&
            requests_sent < phase_end - PhaseItems / 2 + 4)
          drain();
      end
    end
    idle_en = 1'b1;

    drain();
    repeat (6) @(posedge clk);
    fails = hist_sb.mismatches + hist_sb.pending_results.size();
    if (hist_sb.pending_results.size() != 0)
      $display("%0d predicted results never arrived", hist_sb.pending_results.size());
    $display("covered %0d requests (%0d reads) across %0d register settings",
             requests_sent, read_count, setting_count);
    $display("checked %0d results, %0d of them bumps, %0d mismatches",
             hist_sb.results, hist_sb.bumps, hist_sb.mismatches);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("timeout waiting for the block");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
